@@ design/nef_pkg.sv @@
// types and constants shared by the edit-code formatter modules
package nef_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic [7:0]         edit_code;
    logic [5:0]         field_width;
    logic [3:0]         decimal_places;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
  } out_item_t;

  typedef enum logic [1:0] {
    SIGN_CR       = 2'd0,
    SIGN_TRAIL    = 2'd1,
    SIGN_LEAD     = 2'd2
  } sign_style_t;

  // classified job handed from front to back
  typedef struct packed {
    logic [31:0]  mag;
    logic         neg;
    sign_style_t  style;
    logic         comma;
    logic         point;
    logic [5:0]   field_width;
    logic [3:0]   dec;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIGITS = 2'd1,
    ST_BUILD  = 2'd2,
    ST_EMIT   = 2'd3
  } back_state_t;

  localparam logic [7:0] CH_J     = 8'h4A;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_Q     = 8'h51;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;
  localparam logic [7:0] CH_THREE = 8'h33;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_SPACE = 8'h20;

  localparam int NDIG = 20;
  // longest text is well under 32 chars
  localparam int TXT_DEPTH = 32;

endpackage

@@ design/nef_front.sv @@
// front end: takes an item, classifies the code and takes the magnitude
module nef_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  nef_pkg::in_item_t in_data,
  output logic             in_stall,
  output logic             job_valid,
  output nef_pkg::job_t    job,
  input  logic             job_stall
);

  nef_pkg::job_t cls;
  logic [7:0] code;
  logic [7:0] base;
  logic       full;

  always_comb begin
    code = in_data.edit_code;
    base = code;
    cls.style = nef_pkg::SIGN_CR;
    if (code >= nef_pkg::CH_J && code <= nef_pkg::CH_M) begin
      cls.style = nef_pkg::SIGN_TRAIL;
      base = nef_pkg::CH_ONE + (code - nef_pkg::CH_J);
    end else if (code >= nef_pkg::CH_N && code <= nef_pkg::CH_Q) begin
      cls.style = nef_pkg::SIGN_LEAD;
      base = nef_pkg::CH_ONE + (code - nef_pkg::CH_N);
    end
    cls.neg = in_data.value[31];
    cls.mag = cls.neg ? (32'd0 - in_data.value) : in_data.value;
    cls.comma = (base == nef_pkg::CH_ONE) || (base == nef_pkg::CH_THREE);
    cls.point = (base == nef_pkg::CH_ONE) || (base == nef_pkg::CH_TWO) ||
                (in_data.decimal_places != 4'd0);
    cls.field_width = in_data.field_width;
    cls.dec = in_data.decimal_places;
  end

  // single-entry queue between front and back
  assign full = job_valid;
  assign in_stall = full && job_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      job <= cls;
    end
  end

endmodule

@@ design/nef_back.sv @@
// back end: extracts digits one per cycle, builds the text, emits characters
module nef_back #(
  parameter int OUT_CAP = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  nef_pkg::job_t     job,
  output logic              job_stall,
  output logic              out_valid,
  output nef_pkg::out_item_t out_data,
  input  logic              out_stall
);

  localparam int CAP = (OUT_CAP - 1 > 63) ? 63 : OUT_CAP - 1;

  nef_pkg::back_state_t state, state_next;
  nef_pkg::job_t        cur;
  logic [31:0]          mag;
  logic [3:0]           dig [nef_pkg::NDIG];
  logic [4:0]           nd;
  logic [4:0]           bi;      // digit index while building
  logic [1:0]           phase;   // build sub-step
  logic [7:0]           txt [nef_pkg::TXT_DEPTH];
  logic [5:0]           len;
  logic [5:0]           total;
  logic [5:0]           pad;
  logic [5:0]           k;

  logic [31:0] q10;
  logic [3:0]  r10;
  logic [63:0] prod;
  logic        dig_done;
  logic        emit_take;
  logic        out_free;
  logic [4:0]  rel;
  logic        comma_here;

  // divide by ten through reciprocal multiply; the remainder comes from the quotient
  always_comb begin
    prod = {32'd0, mag} * 64'hCCCC_CCCD;
    q10 = 32'(prod >> 35);
    r10 = 4'(mag - q10 * 32'd10);
  end

  // comma after an integer digit three, six, nine, twelve or fifteen places above the units digit
  assign rel = bi - {1'b0, cur.dec};
  assign comma_here = cur.comma && (bi > {1'b0, cur.dec}) &&
                      (rel == 5'd3 || rel == 5'd6 || rel == 5'd9 ||
                       rel == 5'd12 || rel == 5'd15);

  assign dig_done = (mag == 32'd0) && (nd != 5'd0) && ({1'b0, nd} >= {2'b0, cur.dec} + 6'd1);
  assign out_free = !out_valid || !out_stall;
  assign emit_take = (state == nef_pkg::ST_EMIT) && out_free;
  assign job_stall = (state != nef_pkg::ST_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      nef_pkg::ST_IDLE:   if (job_valid) state_next = nef_pkg::ST_DIGITS;
      nef_pkg::ST_DIGITS: if (dig_done) state_next = nef_pkg::ST_BUILD;
      nef_pkg::ST_BUILD:  if (phase == 2'd3) state_next = nef_pkg::ST_EMIT;
      nef_pkg::ST_EMIT:   if (emit_take && k == total - 6'd1) state_next = nef_pkg::ST_IDLE;
      default:            state_next = nef_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nef_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit_take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end

    case (state)
      nef_pkg::ST_IDLE: begin
        cur <= job;
        mag <= job.mag;
        nd <= 5'd0;
        phase <= 2'd0;
        k <= 6'd0;
        len <= (job.style == nef_pkg::SIGN_LEAD) ? 6'd1 : 6'd0;
        if (job.style == nef_pkg::SIGN_LEAD) begin
          txt[0] <= job.neg ? nef_pkg::CH_MINUS : nef_pkg::CH_PLUS;
        end
      end
      nef_pkg::ST_DIGITS: begin
        if (!dig_done && nd < 5'(nef_pkg::NDIG)) begin
          dig[nd] <= (mag != 32'd0) ? r10 : 4'd0;
          mag <= q10;
          nd <= nd + 5'd1;
        end
        bi <= nd - 5'd1;
      end
      nef_pkg::ST_BUILD: begin
        // phase 0: integer digits with commas; 1: point and fraction; 2: suffix; 3: width and padding
        case (phase)
          2'd0: begin
            txt[len[4:0]] <= nef_pkg::CH_ZERO + {4'd0, dig[bi]};
            if (comma_here) begin
              txt[len[4:0] + 5'd1] <= nef_pkg::CH_COMMA;
              len <= len + 6'd2;
            end else begin
              len <= len + 6'd1;
            end
            if (bi == {1'b0, cur.dec}) begin
              phase <= 2'd1;
              bi <= {1'b0, cur.dec} - 5'd1;
            end else begin
              bi <= bi - 5'd1;
            end
          end
          2'd1: begin
            if (cur.point) begin
              txt[len[4:0]] <= nef_pkg::CH_POINT;
              if (cur.dec == 4'd0) begin
                txt[len[4:0] + 5'd1] <= nef_pkg::CH_ZERO;
                len <= len + 6'd2;
                phase <= 2'd2;
              end else begin
                // point written, fraction digits follow in this phase
                len <= len + 6'd1;
                cur.point <= 1'b0;
              end
            end else if (cur.dec != 4'd0) begin
              txt[len[4:0]] <= nef_pkg::CH_ZERO + {4'd0, dig[bi]};
              len <= len + 6'd1;
              if (bi == 5'd0) begin
                phase <= 2'd2;
              end else begin
                bi <= bi - 5'd1;
              end
            end else begin
              phase <= 2'd2;
            end
          end
          2'd2: begin
            if (cur.neg && cur.style == nef_pkg::SIGN_TRAIL) begin
              txt[len[4:0]] <= nef_pkg::CH_MINUS;
              len <= len + 6'd1;
            end else if (cur.neg && cur.style == nef_pkg::SIGN_CR) begin
              txt[len[4:0]] <= nef_pkg::CH_C;
              txt[len[4:0] + 5'd1] <= nef_pkg::CH_R;
              len <= len + 6'd2;
            end
            phase <= 2'd3;
          end
          default: begin
            total <= 6'(((cur.field_width > len) ? cur.field_width : len) > 6'(CAP) ?
                        6'(CAP) : ((cur.field_width > len) ? cur.field_width : len));
            pad <= (cur.field_width > len) ? cur.field_width - len : 6'd0;
          end
        endcase
      end
      nef_pkg::ST_EMIT: begin
        if (emit_take) begin
          out_data.text_char <= (k < pad) ? nef_pkg::CH_SPACE : txt[5'(k - pad)];
          out_data.last_char <= (k == total - 6'd1);
          k <= k + 6'd1;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ design/numeric_edit_code_formatter_core.sv @@
// top level of the numeric edit-code formatter
// throughput: one char per cycle while out_stall is low; digits are extracted one per cycle,
// and the back end takes no new item until it has emitted every char of the last one
// reset: synchronous active-high rst clears the queue and the back-end sequencer
module numeric_edit_code_formatter_core #(
  parameter int OUT_CAP = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  nef_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               out_valid,
  output nef_pkg::out_item_t out_data,
  input  logic               out_stall
);

  logic          job_valid;
  logic          job_stall;
  nef_pkg::job_t job;

  nef_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .job_valid(job_valid), .job(job), .job_stall(job_stall)
  );

  nef_back #(.OUT_CAP(OUT_CAP)) u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job(job), .job_stall(job_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

endmodule

@@ dv/numeric_edit_code_formatter_core_test.sv @@
// self-checking testbench for the numeric edit-code formatter core
module numeric_edit_code_formatter_core_test;

  localparam int CAP = 64;
  localparam int STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  nef_pkg::in_item_t in_data = '0;
  logic in_stall;
  logic out_valid;
  nef_pkg::out_item_t out_data;
  logic out_stall = 1'b0;

  numeric_edit_code_formatter_core #(.OUT_CAP(CAP)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_data(in_data), .in_stall(in_stall),
    .out_valid(out_valid), .out_data(out_data), .out_stall(out_stall)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  nef_pkg::out_item_t expected_chars[$];
  int errors = 0;
  int idle_count = 0;
  bit calm = 1'b0;

  // expected text of one item, pushed onto the queue
  function automatic void format_value(nef_pkg::in_item_t it);
    logic [7:0] dig[24];
    logic [7:0] txt[64];
    logic [31:0] mag;
    logic neg;
    logic [7:0] base;
    logic comma, point;
    nef_pkg::sign_style_t style;
    int nd, len, total, pad, dec, width;
    nef_pkg::out_item_t o;
    neg = it.value[31];
    mag = neg ? (32'd0 - it.value) : it.value;
    dec = it.decimal_places;
    width = it.field_width;
    style = nef_pkg::SIGN_CR;
    base = it.edit_code;
    if (it.edit_code >= nef_pkg::CH_J && it.edit_code <= nef_pkg::CH_M) begin
      style = nef_pkg::SIGN_TRAIL;
      base = nef_pkg::CH_ONE + (it.edit_code - nef_pkg::CH_J);
    end else if (it.edit_code >= nef_pkg::CH_N && it.edit_code <= nef_pkg::CH_Q) begin
      style = nef_pkg::SIGN_LEAD;
      base = nef_pkg::CH_ONE + (it.edit_code - nef_pkg::CH_N);
    end
    comma = (base == nef_pkg::CH_ONE || base == nef_pkg::CH_THREE);
    point = (base == nef_pkg::CH_ONE || base == nef_pkg::CH_TWO) || dec > 0;
    nd = 0;
    if (mag == 0) begin
      dig[nd] = nef_pkg::CH_ZERO;
      nd++;
    end
    while (mag > 0 && nd < 20) begin
      dig[nd] = nef_pkg::CH_ZERO + 8'(mag % 10);
      mag = mag / 10;
      nd++;
    end
    while (nd < dec + 1 && nd < 20) begin
      dig[nd] = nef_pkg::CH_ZERO;
      nd++;
    end
    len = 0;
    if (style == nef_pkg::SIGN_LEAD) begin
      txt[len] = neg ? nef_pkg::CH_MINUS : nef_pkg::CH_PLUS;
      len++;
    end
    for (int i = nd - 1; i >= dec; i--) begin
      txt[len] = dig[i];
      len++;
      if (comma && i > dec && ((i - dec) % 3) == 0) begin
        txt[len] = nef_pkg::CH_COMMA;
        len++;
      end
    end
    if (point) begin
      txt[len] = nef_pkg::CH_POINT;
      len++;
      if (dec == 0) begin
        txt[len] = nef_pkg::CH_ZERO;
        len++;
      end else begin
        for (int i = dec - 1; i >= 0; i--) begin
          txt[len] = dig[i];
          len++;
        end
      end
    end
    if (neg && style == nef_pkg::SIGN_TRAIL) begin
      txt[len] = nef_pkg::CH_MINUS;
      len++;
    end else if (neg && style == nef_pkg::SIGN_CR) begin
      txt[len] = nef_pkg::CH_C;
      txt[len + 1] = nef_pkg::CH_R;
      len += 2;
    end
    total = (width > len) ? width : len;
    if (total > CAP - 1) total = CAP - 1;
    if (total > 63) total = 63;
    pad = (width > len) ? width - len : 0;
    for (int k = 0; k < total; k++) begin
      o.text_char = (k < pad) ? nef_pkg::CH_SPACE : txt[k - pad];
      o.last_char = (k == total - 1);
      expected_chars.push_back(o);
    end
  endfunction

  // directed rows; want_text is empty where the predictor decides
  typedef struct {
    nef_pkg::in_item_t item;
    string             want_text;
  } row_t;
  row_t rows[$];

  function automatic nef_pkg::in_item_t mk(logic [31:0] v, logic [7:0] c, int w, int d);
    nef_pkg::in_item_t it;
    it.value = v;
    it.edit_code = c;
    it.field_width = 6'(w);
    it.decimal_places = 4'(d);
    return it;
  endfunction

  function automatic logic [7:0] random_code();
    case ($urandom_range(0, 4))
      0: return nef_pkg::CH_ONE + 8'($urandom_range(0, 3));
      1: return nef_pkg::CH_J + 8'($urandom_range(0, 3));
      2: return nef_pkg::CH_N + 8'($urandom_range(0, 3));
      3: return 8'($urandom_range(0, 255));
      default: return nef_pkg::CH_ZERO + 8'($urandom_range(0, 9));
    endcase
  endfunction

  function automatic nef_pkg::in_item_t random_item();
    nef_pkg::in_item_t it;
    case ($urandom_range(0, 3))
      0: it.value = $urandom;
      1: it.value = $urandom_range(0, 9999);
      2: it.value = -$urandom_range(0, 99999);
      default: it.value = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 31'($urandom)};
    endcase
    it.edit_code = random_code();
    it.field_width = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 20));
    it.decimal_places = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'($urandom_range(0, 9));
    return it;
  endfunction

  task automatic send(nef_pkg::in_item_t it);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    format_value(it);
  endtask

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(0, 99) < 23);
  end

  // compare each accepted char against the oldest expectation
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (out_valid && !out_stall) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char %h last %b", $time, out_data.text_char,
                   out_data.last_char);
          errors++;
        end else begin
          nef_pkg::out_item_t e;
          e = expected_chars.pop_front();
          if (e.text_char !== out_data.text_char || e.last_char !== out_data.last_char) begin
            $display("%0t: expected %h/%b got %h/%b", $time, e.text_char, e.last_char,
                     out_data.text_char, out_data.last_char);
            errors++;
          end
        end
      end
      if (idle_count >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    nef_pkg::out_item_t o;
    int pos;
    rows.push_back('{mk(32'd0, nef_pkg::CH_ONE, 0, 0), "0.0"});
    rows.push_back('{mk(32'd0, 8'h00, 0, 0), "0"});
    rows.push_back('{mk(32'h7FFFFFFF, nef_pkg::CH_ONE, 0, 0), "2,147,483,647.0"});
    rows.push_back('{mk(32'h80000000, nef_pkg::CH_THREE, 0, 0), "2,147,483,648CR"});
    rows.push_back('{mk(32'hFFFFFFFF, nef_pkg::CH_J + 8'd1, 0, 0), "1.0-"});
    rows.push_back('{mk(32'hFFFFFFFF, nef_pkg::CH_N + 8'd3, 0, 0), "-1"});
    rows.push_back('{mk(32'd5, nef_pkg::CH_N, 0, 0), "+5.0"});
    rows.push_back('{mk(32'd12345, nef_pkg::CH_TWO, 8, 2), "  123.45"});
    rows.push_back('{mk(32'd7, 8'hFF, 0, 15), ""});
    rows.push_back('{mk(32'd123, 8'h41, 2, 0), "123"});
    rows.push_back('{mk(32'h80000000, nef_pkg::CH_M, 63, 9), ""});
    rows.push_back('{mk(32'h7FFFFFFF, nef_pkg::CH_Q, 63, 15), ""});
    rows.push_back('{mk(32'hFFFFFC18, nef_pkg::CH_ONE + 8'd3, 0, 9), ""});
    rows.push_back('{mk(32'd1000, nef_pkg::CH_ONE, 0, 0), "1,000.0"});
    rows.push_back('{mk(32'd999, nef_pkg::CH_J + 8'd2, 5, 0), "  999"});
    rows.push_back('{mk(32'hAAAAAAAA, nef_pkg::CH_N + 8'd1, 40, 4), ""});
    rows.push_back('{mk(32'h55555555, nef_pkg::CH_J + 8'd3, 21, 10), ""});
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    foreach (rows[r]) begin
      send(rows[r].item);
      if (rows[r].want_text.len() != 0) begin
        // overwrite the prediction with the typed-in text
        pos = expected_chars.size() - rows[r].want_text.len();
        for (int k = 0; k < rows[r].want_text.len(); k++) begin
          o.text_char = rows[r].want_text[k];
          o.last_char = (k == rows[r].want_text.len() - 1);
          expected_chars[pos + k] = o;
        end
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;
    // wait for the block to drain before going random
    while (expected_chars.size() != 0) @(posedge clk);
    for (int n = 0; n < 415; n++) begin
      calm = (n >= 150 && n < 200);
      send(random_item());
    end
    @(negedge clk);
    in_valid <= 1'b0;
    calm = 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_chars.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
